// ===== sv/pms_pkg.sv =====
// Shared types and constants for the pixel mirror / sepia stream block.
// No dependencies; the other files but pms_stream_if use it by scoped names.
package pms_pkg;

    localparam int CH_W        = 8;
    localparam int ROW_WIDTH_W = 11;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FLIP_ENABLE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEPIA_ENABLE = 2'd2;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    // Item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Sepia matrix in thousandths
    localparam int COEF_W = 10;
    localparam logic [COEF_W-1:0] SEP_RR = 10'd393;
    localparam logic [COEF_W-1:0] SEP_RG = 10'd769;
    localparam logic [COEF_W-1:0] SEP_RB = 10'd189;
    localparam logic [COEF_W-1:0] SEP_GR = 10'd349;
    localparam logic [COEF_W-1:0] SEP_GG = 10'd686;
    localparam logic [COEF_W-1:0] SEP_GB = 10'd168;
    localparam logic [COEF_W-1:0] SEP_BR = 10'd272;
    localparam logic [COEF_W-1:0] SEP_BG = 10'd534;
    localparam logic [COEF_W-1:0] SEP_BB = 10'd131;

    // Weighted sum width: 1351 * 255 < 2^19
    localparam int SUM_W = 19;
    // Exact floor(s / 1000) for s < 255000: (s * 268436) >> 28
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;
    localparam logic [SUM_W-1:0]   SAT_LIMIT  = 19'd255000;
    localparam logic [CH_W-1:0]    CH_MAX     = 8'd255;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [ROW_WIDTH_W-1:0] row_width;
        logic                   flip_enable;
        logic                   sepia_enable;
    } t_cfg;

    typedef struct packed {
        logic            kind;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            row_end;
    } t_out_item;

endpackage

// ===== sv/pms_stream_if.sv =====
// Valid/ready stream channel carrying one word of payload type T.
// Depends on nothing; instantiated with pms_pkg types by the top level's users.
interface pms_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/pms_regs.sv =====
// APB-style configuration registers: row width, flip enable, sepia enable.
// Depends on pms_pkg.
module pms_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pms_pkg::PADDR_W-1:0]       paddr,
    input  logic [pms_pkg::PDATA_W-1:0]       pwdata,
    output logic [pms_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    output pms_pkg::t_cfg                     o_cfg
);

    logic                              wr_en;
    logic [pms_pkg::REG_IDX_W-1:0]     reg_idx;
    pms_pkg::t_cfg                     r_cfg;
    pms_pkg::t_cfg                     n_cfg;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[pms_pkg::PADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                pms_pkg::REG_ROW_WIDTH:    n_cfg.row_width = pwdata[pms_pkg::ROW_WIDTH_W-1:0];
                pms_pkg::REG_FLIP_ENABLE:  n_cfg.flip_enable = pwdata[0];
                pms_pkg::REG_SEPIA_ENABLE: n_cfg.sepia_enable = pwdata[0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pms_pkg::REG_ROW_WIDTH:    prdata = pms_pkg::PDATA_W'(r_cfg.row_width);
            pms_pkg::REG_FLIP_ENABLE:  prdata = pms_pkg::PDATA_W'(r_cfg.flip_enable);
            pms_pkg::REG_SEPIA_ENABLE: prdata = pms_pkg::PDATA_W'(r_cfg.sepia_enable);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_width    <= pms_pkg::ROW_WIDTH_RESET;
            r_cfg.flip_enable  <= 1'b0;
            r_cfg.sepia_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/pms_front.sv =====
// Front end: accepts items, tracks row position, writes and reads the
// ping-pong row banks, and classifies each item as emitting or silent.
// Depends on pms_pkg.
module pms_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pms_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pms_pkg::t_in_item    i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pms_pkg::t_out_item   o_item
);

    localparam int C_BITS = $clog2(MAX_WIDTH);
    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int A_BITS = $clog2(2 * MAX_WIDTH);
    localparam int CMP_W  = (W_BITS > pms_pkg::ROW_WIDTH_W) ? W_BITS : pms_pkg::ROW_WIDTH_W;
    localparam int PIX_W  = 3 * pms_pkg::CH_W;

    logic [CMP_W-1:0]  rw_ext;
    logic [W_BITS-1:0] eff_w;
    logic              accept;
    logic              is_drain;
    logic [C_BITS-1:0] pos;
    logic [W_BITS-1:0] pos_ext;
    logic [W_BITS-1:0] pos_next;
    logic              last;
    logic [C_BITS-1:0] rd_idx;
    logic [A_BITS-1:0] rd_addr;
    logic [A_BITS-1:0] wr_addr;
    logic              wr_en;
    logic              rd_en;
    logic              emit;
    logic [PIX_W-1:0]  in_pix;
    logic [PIX_W-1:0]  out_pix;

    logic [C_BITS-1:0] r_col, n_col;
    logic [C_BITS-1:0] r_drain, n_drain;
    logic              r_wbank, n_wbank;
    logic              r_full, n_full;
    logic              r_s1_v, n_s1_v;
    logic              r_s1_mem;
    logic              r_s1_last;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [PIX_W-1:0]  r_rd_data;
    logic [PIX_W-1:0]  r_bank_mem [2 * MAX_WIDTH];

    // Clamp the configured width into 1..MAX_WIDTH
    assign rw_ext = CMP_W'(i_cfg.row_width);
    always_comb begin
        if (rw_ext == '0) begin
            eff_w = W_BITS'(1);
        end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
            eff_w = W_BITS'(MAX_WIDTH);
        end else begin
            eff_w = W_BITS'(rw_ext);
        end
    end

    assign o_ready  = !r_s1_v || i_ready;
    assign accept   = i_valid && o_ready;
    assign is_drain = (i_item.kind == pms_pkg::KIND_DRAIN);
    assign pos      = is_drain ? r_drain : r_col;
    assign pos_ext  = W_BITS'(pos);
    assign pos_next = pos_ext + W_BITS'(1);
    assign last     = (pos_next >= eff_w);
    assign rd_idx   = (pos_ext < eff_w) ? C_BITS'(eff_w - W_BITS'(1) - pos_ext) : '0;
    assign rd_addr  = r_wbank ? A_BITS'(rd_idx) : A_BITS'(MAX_WIDTH) + A_BITS'(rd_idx);
    assign wr_addr  = r_wbank ? A_BITS'(MAX_WIDTH) + A_BITS'(r_col) : A_BITS'(r_col);
    assign in_pix   = {i_item.red_in, i_item.green_in, i_item.blue_in};

    assign wr_en = accept && !is_drain && i_cfg.flip_enable;
    assign rd_en = accept && r_full && (is_drain || i_cfg.flip_enable);
    assign emit  = is_drain ? r_full : (i_cfg.flip_enable ? r_full : 1'b1);

    always_comb begin
        n_col   = r_col;
        n_drain = r_drain;
        n_wbank = r_wbank;
        n_full  = r_full;
        if (accept) begin
            if (is_drain) begin
                if (r_full) begin
                    if (last) begin
                        n_drain = '0;
                        n_full  = 1'b0;
                    end else begin
                        n_drain = C_BITS'(pos_next);
                    end
                end
            end else begin
                n_col = last ? '0 : C_BITS'(pos_next);
                if (i_cfg.flip_enable && last) begin
                    n_wbank = !r_wbank;
                    n_full  = 1'b1;
                    n_drain = '0;
                end
            end
        end
    end

    always_comb begin
        n_s1_v = r_s1_v;
        if (o_ready) begin
            n_s1_v = accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_drain <= '0;
            r_wbank <= 1'b0;
            r_full  <= 1'b0;
            r_s1_v  <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_drain <= n_drain;
            r_wbank <= n_wbank;
            r_full  <= n_full;
            r_s1_v  <= n_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mem  <= is_drain || i_cfg.flip_enable;
            r_s1_last <= last;
            r_s1_pix  <= in_pix;
        end
    end

    // Row banks: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bank_mem[wr_addr] <= in_pix;
        end
        if (rd_en) begin
            r_rd_data <= r_bank_mem[rd_addr];
        end
    end

    assign out_pix          = r_s1_mem ? r_rd_data : r_s1_pix;
    assign o_valid          = r_s1_v;
    assign o_item.red_out   = out_pix[PIX_W-1 -: pms_pkg::CH_W];
    assign o_item.green_out = out_pix[pms_pkg::CH_W +: pms_pkg::CH_W];
    assign o_item.blue_out  = out_pix[0 +: pms_pkg::CH_W];
    assign o_item.row_end   = r_s1_last;

endmodule

// ===== sv/pms_queue.sv =====
// Short flop-based queue decoupling the front end from the color back end.
// Depends on pms_pkg.
module pms_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pms_pkg::t_out_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pms_pkg::t_out_item   o_item
);

    localparam int PTR_W = (pms_pkg::Q_DEPTH > 1) ? $clog2(pms_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(pms_pkg::Q_DEPTH + 1);

    pms_pkg::t_out_item r_entries [pms_pkg::Q_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != CNT_W'(pms_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_entries[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PTR_W'(pms_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_W'(pms_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entries[r_wptr] <= i_item;
        end
    end

endmodule

// ===== sv/pms_back.sv =====
// Back end: optional sepia matrix in two stages (weighted sums, then
// divide by 1000 with saturation) ending in the output register.
// Depends on pms_pkg.
module pms_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sepia_enable,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pms_pkg::t_out_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pms_pkg::t_out_item   o_item
);

    localparam int SW = pms_pkg::SUM_W;
    localparam int PW = pms_pkg::SUM_W + pms_pkg::RECIP_W;

    function automatic logic [pms_pkg::CH_W-1:0] div_sat(input logic [SW-1:0] s);
        logic [PW-1:0] p;
        p = PW'(s) * PW'(pms_pkg::RECIP_1000);
        if (s >= pms_pkg::SAT_LIMIT) begin
            return pms_pkg::CH_MAX;
        end
        return p[pms_pkg::RECIP_SHIFT +: pms_pkg::CH_W];
    endfunction

    logic               adv1;
    logic               adv2;
    logic [SW-1:0]      sum_r, sum_g, sum_b;
    logic [SW-1:0]      r_b1_sum_r, r_b1_sum_g, r_b1_sum_b;
    pms_pkg::t_out_item r_b1_item;
    logic               r_b1_v;
    pms_pkg::t_out_item r_b2_item;
    logic               r_b2_v;
    pms_pkg::t_out_item n_b2_item;

    assign adv2    = !r_b2_v || i_ready;
    assign adv1    = !r_b1_v || adv2;
    assign o_ready = adv1;

    assign sum_r = SW'(pms_pkg::SEP_RR) * SW'(i_item.red_out)
                 + SW'(pms_pkg::SEP_RG) * SW'(i_item.green_out)
                 + SW'(pms_pkg::SEP_RB) * SW'(i_item.blue_out);
    assign sum_g = SW'(pms_pkg::SEP_GR) * SW'(i_item.red_out)
                 + SW'(pms_pkg::SEP_GG) * SW'(i_item.green_out)
                 + SW'(pms_pkg::SEP_GB) * SW'(i_item.blue_out);
    assign sum_b = SW'(pms_pkg::SEP_BR) * SW'(i_item.red_out)
                 + SW'(pms_pkg::SEP_BG) * SW'(i_item.green_out)
                 + SW'(pms_pkg::SEP_BB) * SW'(i_item.blue_out);

    always_comb begin
        n_b2_item = r_b1_item;
        if (i_sepia_enable) begin
            n_b2_item.red_out   = div_sat(r_b1_sum_r);
            n_b2_item.green_out = div_sat(r_b1_sum_g);
            n_b2_item.blue_out  = div_sat(r_b1_sum_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
        end else begin
            if (adv1) begin
                r_b1_v <= i_valid;
            end
            if (adv2) begin
                r_b2_v <= r_b1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_b1_sum_r <= sum_r;
            r_b1_sum_g <= sum_g;
            r_b1_sum_b <= sum_b;
            r_b1_item  <= i_item;
        end
        if (adv2 && r_b1_v) begin
            r_b2_item <= n_b2_item;
        end
    end

    assign o_valid = r_b2_v;
    assign o_item  = r_b2_item;

endmodule

// ===== sv/pixel_mirror_sepia_stream.sv =====
// Path: a word that emits a result passes the front register, the queue, the sepia-sum
//   register and the output register, in that order.
// Throughput: one word per cycle while the output side keeps up, set by the single write
//   and single read port of the row banks, each used at most once per word.
// Reset: synchronous, active low; clears row/drain counters, bank select, stored-row
//   flag, valid bits, queue state, config; data regs and row banks need no clearing.
module pixel_mirror_sepia_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pms_stream_if.sink                        i_pix,
    pms_stream_if.source                      o_pix,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pms_pkg::PADDR_W-1:0]       paddr,
    input  logic [pms_pkg::PDATA_W-1:0]       pwdata,
    output logic [pms_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    // Configuration; user must keep it stable with words in flight; block does not enforce it
    pms_pkg::t_cfg      cfg;

    // Front end to queue
    logic               fq_valid;
    logic               fq_ready;
    pms_pkg::t_out_item fq_item;

    // Queue to back end
    logic               qb_valid;
    logic               qb_ready;
    pms_pkg::t_out_item qb_item;

    pms_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front: count columns, write the current row, read the stored row mirrored.
    // Silent words (row being stored with no prior row, drain with nothing stored)
    // drop here and never reach the queue.
    pms_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_item  (i_pix.data),
        .o_valid (fq_valid),
        .i_ready (fq_ready),
        .o_item  (fq_item)
    );

    // Queue: lets the front keep accepting while the output side stalls, until it fills
    pms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item)
    );

    // Back: sepia matrix and saturation, output register
    pms_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sepia_enable (cfg.sepia_enable),
        .i_valid        (qb_valid),
        .o_ready        (qb_ready),
        .i_item         (qb_item),
        .o_valid        (o_pix.valid),
        .i_ready        (o_pix.ready),
        .o_item         (o_pix.data)
    );

endmodule

// ===== sv/pms_checker.sv =====
// Port-level checks for pixel_mirror_sepia_stream, attached by bind.
// Depends on pms_pkg and the top level's ports.
module pms_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input pms_pkg::t_out_item i_out_data
);

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    // Reset leaves the front free to accept
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");

    // A free output in the previous cycle drains the queue enough to free the front
    a_decouple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_out_ready) |-> i_in_ready)
        else $error("input stalled although output side was free");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output word changed");

endmodule

bind pixel_mirror_sepia_stream pms_checker u_pms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  (o_pix.data)
);

// ===== tb/pixel_mirror_sepia_stream_tb.sv =====
// Self-checking testbench for pixel_mirror_sepia_stream: row mirroring, sepia and row ends.
// Depends on pms_pkg (types, register indexes, kinds) and pms_stream_if (word channels).
// A scoreboard class forecasts every output word; plain tasks drive the stream and APB ports.

class mirrored_pixel_board #(int DEPTH = 1024);
    pms_pkg::t_out_item expected_pixels[$];
    int                 errors;

    // Forecast state: ping-pong rows, counters and a shadow of the registers
    logic [23:0] bank [0:2*DEPTH-1];
    int unsigned col_cnt;
    int unsigned drain_pos;
    bit          wr_bank;
    bit          row_stored;
    logic [10:0] width_reg;
    bit          flip_on;
    bit          sepia_on;

    function new();
        errors     = 0;
        col_cnt    = 0;
        drain_pos  = 0;
        wr_bank    = 1'b0;
        row_stored = 1'b0;
        width_reg  = pms_pkg::ROW_WIDTH_RESET;
        flip_on    = 1'b0;
        sepia_on   = 1'b0;
    endfunction

    function void set_reg(logic [pms_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            pms_pkg::REG_ROW_WIDTH:    width_reg = value[10:0];
            pms_pkg::REG_FLIP_ENABLE:  flip_on   = value[0];
            pms_pkg::REG_SEPIA_ENABLE: sepia_on  = value[0];
            default: ;
        endcase
    endfunction

    function int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > DEPTH) return DEPTH;
        return 32'(width_reg);
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    // One sepia channel: weighted sum in thousandths, truncated, clipped at 255
    function logic [7:0] tone(input int unsigned kr, input int unsigned kg,
                              input int unsigned kb, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
        int unsigned s;
        s = (kr * r + kg * g + kb * b) / 1000;
        return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    function logic [23:0] mirrored_at(int unsigned pos, int unsigned w);
        int unsigned idx;
        idx = (pos < w) ? (w - 1 - pos) : 0;
        return bank[(wr_bank ? 0 : DEPTH) + (idx % DEPTH)];
    endfunction

    function void emit_expected(logic [23:0] pix, bit last);
        pms_pkg::t_out_item px;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        r = pix[23:16];
        g = pix[15:8];
        b = pix[7:0];
        if (sepia_on) begin
            px.red_out   = tone(393, 769, 189, r, g, b);
            px.green_out = tone(349, 686, 168, r, g, b);
            px.blue_out  = tone(272, 534, 131, r, g, b);
        end else begin
            px.red_out   = r;
            px.green_out = g;
            px.blue_out  = b;
        end
        px.row_end = last;
        expected_pixels.push_back(px);
    endfunction

    function void record_input(pms_pkg::t_in_item word);
        int unsigned w;
        bit          last;
        logic [23:0] pix;
        w   = active_width();
        pix = {word.red_in, word.green_in, word.blue_in};
        if (word.kind == pms_pkg::KIND_DRAIN) begin
            if (!row_stored) return;
            last = (drain_pos + 1 >= w);
            emit_expected(mirrored_at(drain_pos, w), last);
            if (last) begin
                drain_pos  = 0;
                row_stored = 1'b0;
            end else begin
                drain_pos++;
            end
            return;
        end
        last = (col_cnt + 1 >= w);
        if (flip_on) begin
            if (row_stored) emit_expected(mirrored_at(col_cnt, w), last);
            bank[(wr_bank ? DEPTH : 0) + (col_cnt % DEPTH)] = pix;
            if (last) begin
                wr_bank    = ~wr_bank;
                row_stored = 1'b1;
                drain_pos  = 0;
            end
        end else begin
            emit_expected(pix, last);
        end
        col_cnt = last ? 0 : col_cnt + 1;
    endfunction

    function void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endfunction

    function void compare_output(pms_pkg::t_out_item got);
        pms_pkg::t_out_item want;
        if (expected_pixels.size() == 0) begin
            $error("output word with nothing forecast: r=%0d g=%0d b=%0d row_end=%0d",
                   got.red_out, got.green_out, got.blue_out, got.row_end);
            errors++;
            return;
        end
        want = expected_pixels.pop_front();
        check_field("red_out",   want.red_out,   got.red_out);
        check_field("green_out", want.green_out, got.green_out);
        check_field("blue_out",  want.blue_out,  got.blue_out);
        check_field("row_end",   want.row_end,   got.row_end);
    endfunction
endclass

module pixel_mirror_sepia_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 1024;
    localparam int SETTLE_CYCLES = 8;       // leaves slack for dropped words
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_WORDS  = 300;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [pms_pkg::PADDR_W-1:0]  paddr;
    logic [pms_pkg::PDATA_W-1:0]  pwdata;
    logic [pms_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    pms_stream_if #(.T(pms_pkg::t_in_item))  pix_in_if ();
    pms_stream_if #(.T(pms_pkg::t_out_item)) pix_out_if ();

    pixel_mirror_sepia_stream #(.MAX_WIDTH(MAX_W)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in_if),
        .o_pix   (pix_out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mirrored_pixel_board #(MAX_W) sb;

    bit src_quiet;      // sender offers back to back when set
    bit hold_req;       // ask the receiver for one long hold-off
    int words_live;     // accepted words that the block acts on
    int cycle_count;

    // 2 ns clock, low phase first
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic pms_pkg::t_in_item make_word(logic kind);
        pms_pkg::t_in_item word;
        word.kind     = kind;
        word.red_in   = 8'($urandom_range(0, 255));
        word.green_in = 8'($urandom_range(0, 255));
        word.blue_in  = 8'($urandom_range(0, 255));
        return word;
    endfunction

    function automatic pms_pkg::t_in_item pixel_of(logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b);
        pms_pkg::t_in_item word;
        word.kind     = pms_pkg::KIND_PIXEL;
        word.red_in   = r;
        word.green_in = g;
        word.blue_in  = b;
        return word;
    endfunction

    // Every task below starts on a falling edge with nothing driven yet in that step
    // and returns on a later falling edge, again with nothing driven in it.

    // Offer one word after an optional gap; hold valid high until it is taken.
    task automatic offer(pms_pkg::t_in_item word);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            pix_in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_in_if.valid <= 1'b1;
        pix_in_if.data  <= word;
        @(posedge i_clk);
        while (!pix_in_if.ready) @(posedge i_clk);
        // A drain with no stored row is ignored by the block: don't count it
        if (word.kind == pms_pkg::KIND_PIXEL || sb.row_stored) words_live++;
        sb.record_input(word);
        @(negedge i_clk);
    endtask

    // Drop valid, then wait until every forecast word has come back and the pipe is empty.
    task automatic wait_drained();
        pix_in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, register taken at the edge with pready high
    task automatic apb_write(logic [pms_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(int width, bit flip, bit sepia);
        apb_write(pms_pkg::REG_ROW_WIDTH, 32'(width));
        apb_write(pms_pkg::REG_FLIP_ENABLE, {31'd0, flip});
        apb_write(pms_pkg::REG_SEPIA_ENABLE, {31'd0, sepia});
    endtask

    // Stream whole rows of random pixels, mixing in drain words at the given percentage.
    task automatic stream_rows(int rows, int drain_pct);
        int done;
        bit ends;
        done = 0;
        while (done < rows) begin
            if ($urandom_range(0, 99) < drain_pct) offer(make_word(pms_pkg::KIND_DRAIN));
            ends = (sb.col_cnt + 1 >= sb.active_width());
            offer(make_word(pms_pkg::KIND_PIXEL));
            if (ends) done++;
        end
    endtask

    // Check every output word taken at a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out_if.valid && pix_out_if.ready) begin
            sb.compare_output(pix_out_if.data);
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off on request
    initial begin : receiver
        int gap;
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pix_out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                pix_out_if.ready <= 1'b1;
            end else if (quiet > 0) begin
                pix_out_if.ready <= 1'b1;
                quiet--;
            end else begin
                if ($urandom_range(0, 49) == 0) quiet = $urandom_range(50, 200);
                gap = pick_gap();
                if (gap == 0) begin
                    pix_out_if.ready <= 1'b1;
                end else begin
                    pix_out_if.ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int goal;
        int width;
        sb         = new();
        src_quiet  = 1'b0;
        hold_req   = 1'b0;
        words_live = 0;

        // Drive every input to a known value while reset is held low
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        pix_in_if.valid  <= 1'b0;
        pix_in_if.data   <= '0;
        pix_out_if.ready <= 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings (width 1024, pass-through): a drain with no stored row yields
        // nothing, then pixels go straight out, leaving the row open at column 5
        offer(make_word(pms_pkg::KIND_DRAIN));
        offer(pixel_of(8'd0, 8'd0, 8'd0));
        offer(pixel_of(8'd255, 8'd255, 8'd255));
        offer(pixel_of(8'd170, 8'd85, 8'd15));
        offer(pixel_of(8'd1, 8'd128, 8'd254));
        offer(pixel_of(8'd240, 8'd0, 8'd77));
        wait_drained();

        // Shrink the width mid-row: column 5 is past the new width, so it ends the row
        apb_write(pms_pkg::REG_ROW_WIDTH, 32'd3);
        offer(pixel_of(8'd9, 8'd8, 8'd7));
        repeat (3) offer(make_word(pms_pkg::KIND_PIXEL));
        wait_drained();

        // Mirror plus sepia at width 3: the first row is stored silently, the second
        // pushes out the first reversed, drains flush the second; white must clip
        configure(3, 1'b1, 1'b1);
        offer(pixel_of(8'd255, 8'd255, 8'd255));
        offer(pixel_of(8'd0, 8'd0, 8'd0));
        offer(pixel_of(8'd200, 8'd10, 8'd90));
        offer(pixel_of(8'd1, 8'd2, 8'd3));
        offer(pixel_of(8'd128, 8'd64, 8'd32));
        offer(pixel_of(8'd255, 8'd0, 8'd0));
        repeat (4) offer(make_word(pms_pkg::KIND_DRAIN));
        wait_drained();

        // Width 0 acts as 1: every pixel is a full row
        configure(0, 1'b1, 1'b0);
        offer(make_word(pms_pkg::KIND_PIXEL));
        offer(make_word(pms_pkg::KIND_PIXEL));
        offer(make_word(pms_pkg::KIND_DRAIN));
        offer(make_word(pms_pkg::KIND_DRAIN));
        wait_drained();

        // Long receiver hold-off while the sender keeps offering: fill the block
        configure(4, 1'b0, 1'b1);
        src_quiet = 1'b1;
        hold_req  = 1'b1;
        repeat (40) offer(make_word(pms_pkg::KIND_PIXEL));
        src_quiet = 1'b0;
        wait_drained();

        // Oversized width clamps to the bank depth: one pass-through row must end
        // at the clamped width
        configure(2047, 1'b0, 1'($urandom_range(0, 1)));
        stream_rows(1, 0);
        wait_drained();

        // Random phases. Change the width only with no stored row; a stored row may
        // carry across a phase when the width stays, so drains and pixels read it later.
        goal = words_live + RANDOM_WORDS;
        while (words_live < goal) begin
            if (!sb.row_stored) begin
                case ($urandom_range(0, 9))
                    0:       width = 0;
                    1:       width = 1;
                    2:       width = 2;
                    3:       width = $urandom_range(25, 64);
                    default: width = $urandom_range(3, 24);
                endcase
            end else begin
                width = int'(sb.width_reg);
            end
            configure(width, 1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)));
            src_quiet = ($urandom_range(0, 3) == 0);
            stream_rows($urandom_range(1, 6),
                        ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40));
            if ($urandom_range(0, 2) != 0) begin
                while (sb.row_stored) offer(make_word(pms_pkg::KIND_DRAIN));
            end
            src_quiet = 1'b0;
            wait_drained();
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pms_pkg.sv
sv/pms_stream_if.sv
sv/pms_regs.sv
sv/pms_front.sv
sv/pms_queue.sv
sv/pms_back.sv
sv/pixel_mirror_sepia_stream.sv
sv/pms_checker.sv
tb/pixel_mirror_sepia_stream_tb.sv
